>>> rtl/core/scdd_pkg.sv
package scdd_pkg;

   // configuration register indexes
   localparam logic [1:0] CSR_BIT_TICKS     = 2'd0;
   localparam logic [1:0] CSR_SEGMENT_TICKS = 2'd1;
   localparam logic [1:0] CSR_DISPLAY_TICKS = 2'd2;

   localparam logic [15:0] BIT_TICKS_RST     = 16'd100;
   localparam logic [15:0] SEGMENT_TICKS_RST = 16'd1000;
   localparam logic [23:0] DISPLAY_TICKS_RST = 24'd700000;

   localparam logic [7:0] ASCII_ZERO = 8'd48;
   localparam logic [3:0] LAST_DIGIT = 4'd9;

   typedef enum logic [3:0] {
      PH_IDLE = 4'b0001,
      PH_DATA = 4'b0010,
      PH_STOP = 4'b0100,
      PH_SHOW = 4'b1000
   } phase_type;

   // next-tick view handed from the sequencer to the pin decoder and output stage
   typedef struct packed {
      logic       show;
      logic [3:0] digit;
      logic [2:0] position;
      logic       byte_valid;
      logic [7:0] held_byte;
   } view_type;

   typedef logic [6:0][2:0] seg_row_type;

   // segment codes a..g = 0..6, one octal digit per position, position 0 rightmost
   function automatic seg_row_type seg_row(input logic [3:0] digit);
      seg_row_type row;
      case (digit)
         4'd0: row = 21'o0543210;
         4'd1: row = 21'o0000021;
         4'd2: row = 21'o0064310;
         4'd3: row = 21'o0063210;
         4'd4: row = 21'o0006521;
         4'd5: row = 21'o0065320;
         4'd6: row = 21'o0654320;
         4'd7: row = 21'o0000210;
         4'd8: row = 21'o6543210;
         4'd9: row = 21'o0065210;
         default: row = '0;
      endcase
      return row;
   endfunction

   function automatic logic [2:0] seg_count(input logic [3:0] digit);
      logic [2:0] n;
      case (digit)
         4'd0: n = 3'd6;
         4'd1: n = 3'd2;
         4'd2: n = 3'd5;
         4'd3: n = 3'd5;
         4'd4: n = 3'd4;
         4'd5: n = 3'd5;
         4'd6: n = 3'd6;
         4'd7: n = 3'd3;
         4'd8: n = 3'd7;
         4'd9: n = 3'd5;
         default: n = 3'd0;
      endcase
      return n;
   endfunction

   // pin bits: pb0 = bit 0, pb2 = bit 1, pb3 = bit 2, pb4 = bit 3
   function automatic logic [3:0] seg_anode(input logic [2:0] code);
      logic [3:0] p;
      case (code)
         3'd0, 3'd1, 3'd2: p = 4'd2;
         3'd3, 3'd4, 3'd5: p = 4'd1;
         3'd6:             p = 4'd4;
         default:          p = 4'd0;
      endcase
      return p;
   endfunction

   function automatic logic [3:0] seg_cathode(input logic [2:0] code);
      logic [3:0] p;
      case (code)
         3'd0, 3'd3, 3'd6: p = 4'd8;
         3'd1, 3'd4:       p = 4'd4;
         3'd2:             p = 4'd1;
         3'd5:             p = 4'd2;
         default:          p = 4'd0;
      endcase
      return p;
   endfunction

endpackage

>>> rtl/core/scdd_rx_seq.sv
module scdd_rx_seq (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step,
   input  logic                   serial_level,
   input  logic [15:0]            bit_ticks,
   input  logic [15:0]            segment_ticks,
   input  logic [23:0]            display_ticks,
   output scdd_pkg::view_type     view
);

   scdd_pkg::phase_type phase_ff, phase_in;
   logic [16:0] phase_timer_ff, phase_timer_in;
   logic [2:0]  bit_count_ff, bit_count_in;
   logic [7:0]  shift_byte_ff, shift_byte_in;
   logic [3:0]  digit_ff, digit_in;
   logic [2:0]  position_ff, position_in;
   logic [15:0] seg_timer_ff, seg_timer_in;
   logic [23:0] elapsed_ff, elapsed_in;
   logic [7:0]  held_ff, held_in;

   logic [15:0] seg_time;
   logic [16:0] long_wait;
   logic [7:0]  rx_digit;
   logic [3:0]  fit_digit;
   logic [23:0] fit_base;
   logic [18:0] pass_ticks;
   logic [24:0] fit_sum;
   logic        fits;
   logic [15:0] seg_timer_inc;
   logic [2:0]  position_inc;
   logic        byte_done;

   assign seg_time  = (segment_ticks == 16'd0) ? 16'd1 : segment_ticks;
   assign long_wait = {1'b0, bit_ticks} + {2'b00, bit_ticks[15:1]};
   assign rx_digit  = (shift_byte_ff >= scdd_pkg::ASCII_ZERO) ?
                      shift_byte_ff - scdd_pkg::ASCII_ZERO : shift_byte_ff;

   // one budget check shared by the accepting tick and the end of each pass
   assign fit_digit  = (phase_ff == scdd_pkg::PH_STOP) ? rx_digit[3:0] : digit_ff;
   assign fit_base   = (phase_ff == scdd_pkg::PH_STOP) ? 24'd0 : elapsed_ff + 24'd1;
   assign pass_ticks = {3'b000, seg_time} * {16'd0, scdd_pkg::seg_count(fit_digit)};
   assign fit_sum    = {1'b0, fit_base} + {6'd0, pass_ticks};
   assign fits       = fit_sum <= {1'b0, display_ticks};

   assign seg_timer_inc = seg_timer_ff + 16'd1;
   assign position_inc  = position_ff + 3'd1;

   always_comb begin
      phase_in       = phase_ff;
      phase_timer_in = phase_timer_ff;
      bit_count_in   = bit_count_ff;
      shift_byte_in  = shift_byte_ff;
      digit_in       = digit_ff;
      position_in    = position_ff;
      seg_timer_in   = seg_timer_ff;
      elapsed_in     = elapsed_ff;
      held_in        = held_ff;
      byte_done      = 1'b0;
      case (phase_ff)
         scdd_pkg::PH_IDLE: begin
            if (!serial_level) begin
               phase_in       = scdd_pkg::PH_DATA;
               phase_timer_in = long_wait;
               bit_count_in   = 3'd0;
               shift_byte_in  = 8'd0;
            end
         end
         scdd_pkg::PH_DATA: begin
            if (phase_timer_ff <= 17'd1) begin
               shift_byte_in = shift_byte_ff | ({7'd0, serial_level} << bit_count_ff);
               if (bit_count_ff == 3'd7) begin
                  bit_count_in   = 3'd0;
                  phase_in       = scdd_pkg::PH_STOP;
                  phase_timer_in = long_wait;
               end else begin
                  bit_count_in   = bit_count_ff + 3'd1;
                  phase_timer_in = {1'b0, bit_ticks};
               end
            end else begin
               phase_timer_in = phase_timer_ff - 17'd1;
            end
         end
         scdd_pkg::PH_STOP: begin
            if (phase_timer_ff <= 17'd1) begin
               byte_done      = 1'b1;
               held_in        = shift_byte_ff;
               phase_timer_in = 17'd0;
               position_in    = 3'd0;
               seg_timer_in   = 16'd0;
               elapsed_in     = 24'd0;
               phase_in       = scdd_pkg::PH_IDLE;
               if (rx_digit <= {4'd0, scdd_pkg::LAST_DIGIT}) begin
                  digit_in = rx_digit[3:0];
                  if (fits) begin
                     phase_in = scdd_pkg::PH_SHOW;
                  end
               end
            end else begin
               phase_timer_in = phase_timer_ff - 17'd1;
            end
         end
         scdd_pkg::PH_SHOW: begin
            seg_timer_in = seg_timer_inc;
            elapsed_in   = elapsed_ff + 24'd1;
            if (seg_timer_inc >= seg_time) begin
               seg_timer_in = 16'd0;
               position_in  = position_inc;
               if (position_inc >= scdd_pkg::seg_count(digit_ff)) begin
                  position_in = 3'd0;
                  if (!fits) begin
                     phase_in = scdd_pkg::PH_IDLE;
                  end
               end
            end
         end
         default: begin
            phase_in = scdd_pkg::PH_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= scdd_pkg::PH_IDLE;
         phase_timer_ff <= 17'd0;
         bit_count_ff   <= 3'd0;
         shift_byte_ff  <= 8'd0;
         digit_ff       <= 4'd0;
         position_ff    <= 3'd0;
         seg_timer_ff   <= 16'd0;
         elapsed_ff     <= 24'd0;
         held_ff        <= 8'd0;
      end else if (step) begin
         phase_ff       <= phase_in;
         phase_timer_ff <= phase_timer_in;
         bit_count_ff   <= bit_count_in;
         shift_byte_ff  <= shift_byte_in;
         digit_ff       <= digit_in;
         position_ff    <= position_in;
         seg_timer_ff   <= seg_timer_in;
         elapsed_ff     <= elapsed_in;
         held_ff        <= held_in;
      end
   end

   assign view.show       = (phase_in == scdd_pkg::PH_SHOW);
   assign view.digit      = digit_in;
   assign view.position   = position_in;
   assign view.byte_valid = byte_done;
   assign view.held_byte  = held_in;

endmodule

>>> rtl/core/scdd_seg_decode.sv
module scdd_seg_decode (
   input  scdd_pkg::view_type view,
   output logic [3:0]         pin_direction,
   output logic [3:0]         pin_level
);

   scdd_pkg::seg_row_type row;
   logic [2:0] code;
   logic [3:0] anode;

   assign row   = scdd_pkg::seg_row(view.digit);
   assign code  = (view.position == 3'd7) ? 3'd7 : row[view.position];
   assign anode = scdd_pkg::seg_anode(code);

   // nothing lit outside a show
   assign pin_direction = view.show ? (anode | scdd_pkg::seg_cathode(code)) : 4'd0;
   assign pin_level     = view.show ? anode : 4'd0;

endmodule

>>> rtl/core/serial_digit_charlieplex_display.sv
// serial digit display with a charlieplexed seven-segment readout
//
// req channel: one beat per timing tick, carrying the sampled serial line
// (idle high). an 8n1 receiver samples eight data bits lsb first, waits
// out the stop bit and turns the byte into a digit (minus 48 when 48 or
// above). digits 0 to 9 are shown one segment at a time on the four pins.
// rsp channel: exactly one beat for every req beat, in order, carrying the
// pin drive enables and levels, the byte strobe, the last byte and the
// displaying flag as they stand after that tick.
// csr channel: register index and data, always ready; writes are meant for
// idle periods only (0 bit_ticks, 1 segment_ticks, 2 display_ticks).
// latency: the rsp beat appears the cycle after its req beat is taken.
// throughput: one tick per cycle while rsp beats are taken; the whole tick is
// worked out between the sequencer state registers and the rsp output register.
// stall: req_ready drops only while the output register holds a beat that
// the receiver does not take; no beat is lost or repeated.
// reset: sequencer idle, all counters zero, registers at their defaults,
// rsp channel empty.
module serial_digit_charlieplex_display (
   input  logic        clock,
   input  logic        reset,
   // tick input
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_serial_level,
   // per-tick result
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [3:0]  rsp_pin_direction,
   output logic [3:0]  rsp_pin_level,
   output logic        rsp_byte_valid,
   output logic [7:0]  rsp_received_byte,
   output logic        rsp_displaying,
   // configuration writes
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [23:0] csr_data
);

   logic [15:0] bit_ticks_ff;
   logic [15:0] segment_ticks_ff;
   logic [23:0] display_ticks_ff;

   logic               req_fire;
   scdd_pkg::view_type view;
   logic [3:0]         pin_direction;
   logic [3:0]         pin_level;

   logic       rsp_valid_ff;
   logic [3:0] pin_direction_ff;
   logic [3:0] pin_level_ff;
   logic       byte_valid_ff;
   logic [7:0] received_byte_ff;
   logic       displaying_ff;

   // csr writes are always accepted
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         bit_ticks_ff     <= scdd_pkg::BIT_TICKS_RST;
         segment_ticks_ff <= scdd_pkg::SEGMENT_TICKS_RST;
         display_ticks_ff <= scdd_pkg::DISPLAY_TICKS_RST;
      end else if (csr_valid) begin
         case (csr_index)
            scdd_pkg::CSR_BIT_TICKS:     bit_ticks_ff     <= csr_data[15:0];
            scdd_pkg::CSR_SEGMENT_TICKS: segment_ticks_ff <= csr_data[15:0];
            scdd_pkg::CSR_DISPLAY_TICKS: display_ticks_ff <= csr_data;
            default: begin
            end
         endcase
      end
   end

   // take a new tick whenever the output register is free or being emptied
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;

   scdd_rx_seq u_rx_seq (
      .clock         (clock),
      .reset         (reset),
      .step          (req_fire),
      .serial_level  (req_serial_level),
      .bit_ticks     (bit_ticks_ff),
      .segment_ticks (segment_ticks_ff),
      .display_ticks (display_ticks_ff),
      .view          (view)
   );

   scdd_seg_decode u_seg_decode (
      .view          (view),
      .pin_direction (pin_direction),
      .pin_level     (pin_level)
   );

   // rsp output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         pin_direction_ff <= pin_direction;
         pin_level_ff     <= pin_level;
         byte_valid_ff    <= view.byte_valid;
         received_byte_ff <= view.held_byte;
         displaying_ff    <= view.show;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_pin_direction = pin_direction_ff;
   assign rsp_pin_level     = pin_level_ff;
   assign rsp_byte_valid    = byte_valid_ff;
   assign rsp_received_byte = received_byte_ff;
   assign rsp_displaying    = displaying_ff;

endmodule
